// ===== hdl/ptd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-input perceptron trainer.
// Used by ptd_alu and perceptron_trainer_2d; depends on nothing else.

package ptd_pkg;

    // Fixed-point formats of the features and the weights.
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int WEIGHT_BITS   = 32;
    localparam int EPOCH_BITS    = 16;
    localparam int COUNT_BITS    = 9;
    localparam int OP_BITS       = 2;
    localparam int CFG_ADDR_BITS = 2;

    // Product and activation widths; the activation is exact at these sizes.
    localparam int PROD_BITS = WEIGHT_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;

    // The value 1.0 in weight format.
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRACTION_BITS;

    // Reset value of the sweep limit.
    localparam logic [EPOCH_BITS-1:0] MAX_EPOCHS_RESET = EPOCH_BITS'(1000);

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_TRAIN   = 2'd1,
        OP_PREDICT = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_INIT_BIAS  = 2'd0,
        CFG_INIT_Y     = 2'd1,
        CFG_INIT_X     = 2'd2,
        CFG_MAX_EPOCHS = 2'd3
    } cfg_addr_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EPOCH,
        ST_SWEEP,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ACC,
        ST_DECIDE,
        ST_UPD_X,
        ST_UPD_Y,
        ST_UPD_B,
        ST_DONE
    } state_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_MUL_FIRST,
        ALU_MUL_NEXT,
        ALU_ACC
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    subtract;
    } alu_ctrl_t;

    typedef struct packed {
        logic act_neg;
        logic act_zero;
        logic clipped;
    } alu_stat_t;

    // One stored training example.
    typedef struct packed {
        logic                   label;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] x;
    } example_t;

endpackage

// ===== hdl/ptd_alu.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: one multiplier feeding an activation accumulator,
// plus one saturating weight adder. Depends on ptd_pkg.

module ptd_alu (
    input  logic                                aclk,
    input  ptd_pkg::alu_ctrl_t                  ctrl,
    input  logic signed [ptd_pkg::WEIGHT_BITS-1:0] mul_weight,
    input  logic signed [ptd_pkg::SAMPLE_BITS-1:0] mul_sample,
    input  logic        [ptd_pkg::WEIGHT_BITS-1:0] bias,
    input  logic        [ptd_pkg::WEIGHT_BITS-1:0] add_weight,
    input  logic        [ptd_pkg::WEIGHT_BITS-1:0] add_step,
    output logic        [ptd_pkg::WEIGHT_BITS-1:0] sum,
    output ptd_pkg::alu_stat_t                  stat
);
    import ptd_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic        [ACC_BITS-1:0]  acc_reg;
    logic        [ACC_BITS-1:0]  acc_seed;
    logic        [ACC_BITS-1:0]  prod_ext;
    logic        [WEIGHT_BITS:0] sum_wide;

    // The bias enters the activation scaled by 1.0 in product format.
    assign acc_seed  = {{(ACC_BITS-WEIGHT_BITS){bias[WEIGHT_BITS-1]}}, bias} << FRACTION_BITS;
    assign prod_ext  = {{(ACC_BITS-PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
    assign prod_next = mul_weight * mul_sample;

    // Multiplier result is registered before it is accumulated.
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            ALU_MUL_FIRST: begin
                prod_reg <= prod_next;
                acc_reg  <= acc_seed;
            end
            ALU_MUL_NEXT: begin
                prod_reg <= prod_next;
                acc_reg  <= acc_reg + prod_ext;
            end
            ALU_ACC: begin
                acc_reg  <= acc_reg + prod_ext;
            end
            default: begin
            end
        endcase
    end

    // Activation flags, then the saturating weight update; one guard bit
    // shows the overflow.
    always_comb begin
        stat.act_neg  = acc_reg[ACC_BITS-1];
        stat.act_zero = (acc_reg == '0);
        if (ctrl.subtract) begin
            sum_wide = {add_weight[WEIGHT_BITS-1], add_weight}
                     - {add_step[WEIGHT_BITS-1], add_step};
        end else begin
            sum_wide = {add_weight[WEIGHT_BITS-1], add_weight}
                     + {add_step[WEIGHT_BITS-1], add_step};
        end
        stat.clipped = (sum_wide[WEIGHT_BITS] != sum_wide[WEIGHT_BITS-1]);
        if (!stat.clipped) begin
            sum = sum_wide[WEIGHT_BITS-1:0];
        end else if (sum_wide[WEIGHT_BITS]) begin
            sum = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
        end else begin
            sum = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end
    end

endmodule

// ===== hdl/perceptron_trainer_2d.sv =====
`timescale 1ns / 1ps
// Top level of the two-input fixed-point perceptron trainer.
// Depends on ptd_pkg and ptd_alu.

// Every input beat returns one result beat. A load or an unused operation
// code is accepted in the idle state and its result is registered at the
// accepting edge itself. A predict passes through the MUL_X, MUL_Y, ACC,
// DECIDE and DONE states before its result is registered: the activation
// is built by one shared 32x16 multiplier over two products and an
// accumulate, then its sign is checked. A train run makes sweeps over the
// stored examples: each example is one example memory read, two
// multiplies, one accumulate and a decision, and each update passes the
// three weights one after another through the saturating adder.
// The block accepts no beat while a train or predict is in progress.

module perceptron_trainer_2d #(
    parameter int MAX_EXAMPLES = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: x_value[15:0], y_value[31:16], target_positive[32],
    //        first_example[33], zero[39:34]
    input  logic [39:0]                         s_tdata,
    // tuser: operation[1:0]
    input  logic [ptd_pkg::OP_BITS-1:0]         s_tuser,
    // Result beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: prediction_positive[0], weight_bias[32:1], weight_y[64:33],
    //        weight_x[96:65], epochs_used[112:97], converged[113],
    //        saturated[114], example_count[123:115], zero[127:124]
    output logic [127:0]                        m_tdata,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [ptd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [ptd_pkg::WEIGHT_BITS-1:0]     cfg_wdata
);
    import ptd_pkg::*;

    localparam int CNT_BITS  = $clog2(MAX_EXAMPLES + 1);
    localparam int ADDR_BITS = (MAX_EXAMPLES > 1) ? $clog2(MAX_EXAMPLES) : 1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_EXAMPLES);

    // Configuration registers.
    logic [WEIGHT_BITS-1:0] init_bias_reg;
    logic [WEIGHT_BITS-1:0] init_y_reg;
    logic [WEIGHT_BITS-1:0] init_x_reg;
    logic [EPOCH_BITS-1:0]  max_epochs_reg;

    // Trainer state.
    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    idx_reg;
    logic [EPOCH_BITS-1:0]  epoch_reg;
    logic [WEIGHT_BITS-1:0] w_bias_reg, w_y_reg, w_x_reg;
    logic [EPOCH_BITS-1:0]  last_epochs_reg;
    logic                   last_conv_reg;
    logic                   sat_reg;
    logic                   clip_reg;
    logic                   clean_reg;
    logic                   predict_reg;
    logic                   pred_reg;

    // Example memory and its registered read word.
    example_t               mem [MAX_EXAMPLES];
    example_t               op_word_reg;
    example_t               in_word;

    // Result register.
    logic                   m_tvalid_reg;
    logic [127:0]           m_tdata_reg;

    // Handshake and decode.
    op_t                    in_op;
    logic                   in_fire;
    logic                   out_free;
    logic                   out_load;
    logic                   out_pred;
    logic                   load_we;
    logic [CNT_BITS-1:0]    load_base;
    logic                   epoch_go;
    logic                   sample_hit;
    logic                   mem_rd;

    // Shared unit hookup.
    alu_ctrl_t              alu_ctrl;
    alu_stat_t              alu_stat;
    logic [WEIGHT_BITS-1:0] mul_weight;
    logic [SAMPLE_BITS-1:0] mul_sample;
    logic [WEIGHT_BITS-1:0] add_weight;
    logic [WEIGHT_BITS-1:0] add_step;
    logic [WEIGHT_BITS-1:0] alu_sum;

    assign in_op    = op_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    assign in_word.x     = s_tdata[SAMPLE_BITS-1:0];
    assign in_word.y     = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_word.label = s_tdata[32];

    // Load: an optional clear, then an append while there is room.
    always_comb begin
        load_base  = s_tdata[33] ? '0 : count_reg;
        load_we    = 1'b0;
        count_next = count_reg;
        if (in_fire && in_op == OP_LOAD) begin
            count_next = load_base;
            if (load_base < CNT_MAX) begin
                load_we    = 1'b1;
                count_next = load_base + CNT_BITS'(1);
            end
        end
    end

    // Training decision: a positive label needs a strictly positive activation.
    assign sample_hit = op_word_reg.label ? (!alu_stat.act_neg && !alu_stat.act_zero)
                                          : alu_stat.act_neg;
    assign epoch_go   = (epoch_reg < max_epochs_reg) && !clean_reg;
    assign mem_rd     = (state_reg == ST_SWEEP) && (idx_reg < count_reg);

    // Sequencer next state and shared unit control.
    always_comb begin
        state_next        = state_reg;
        alu_ctrl.op       = ALU_HOLD;
        alu_ctrl.subtract = !op_word_reg.label;
        mul_weight        = w_x_reg;
        mul_sample        = op_word_reg.x;
        add_weight        = w_x_reg;
        add_step          = {{(WEIGHT_BITS-SAMPLE_BITS){op_word_reg.x[SAMPLE_BITS-1]}},
                             op_word_reg.x};
        out_load          = 1'b0;
        out_pred          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_op)
                        OP_TRAIN:   state_next = ST_EPOCH;
                        OP_PREDICT: state_next = ST_MUL_X;
                        default:    out_load   = 1'b1;
                    endcase
                end
            end
            ST_EPOCH: begin
                state_next = epoch_go ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP: begin
                state_next = mem_rd ? ST_MUL_X : ST_EPOCH;
            end
            ST_MUL_X: begin
                alu_ctrl.op = ALU_MUL_FIRST;
                state_next  = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                alu_ctrl.op = ALU_MUL_NEXT;
                mul_weight  = w_y_reg;
                mul_sample  = op_word_reg.y;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                alu_ctrl.op = ALU_ACC;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (predict_reg) begin
                    state_next = ST_DONE;
                end else if (sample_hit) begin
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_UPD_X;
                end
            end
            ST_UPD_X: begin
                state_next = ST_UPD_Y;
            end
            ST_UPD_Y: begin
                add_weight = w_y_reg;
                add_step   = {{(WEIGHT_BITS-SAMPLE_BITS){op_word_reg.y[SAMPLE_BITS-1]}},
                              op_word_reg.y};
                state_next = ST_UPD_B;
            end
            ST_UPD_B: begin
                add_weight = w_bias_reg;
                add_step   = WEIGHT_ONE;
                state_next = ST_SWEEP;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_pred   = pred_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ptd_alu u_alu (
        .aclk       (aclk),
        .ctrl       (alu_ctrl),
        .mul_weight (mul_weight),
        .mul_sample (mul_sample),
        .bias       (w_bias_reg),
        .add_weight (add_weight),
        .add_step   (add_step),
        .sum        (alu_sum),
        .stat       (alu_stat)
    );

    // Example memory: write on load, registered read while sweeping.
    // A predict parks its features in the same operand register.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            mem[load_base[ADDR_BITS-1:0]] <= in_word;
        end
        if (mem_rd) begin
            op_word_reg <= mem[idx_reg[ADDR_BITS-1:0]];
        end else if (in_fire && in_op == OP_PREDICT) begin
            op_word_reg <= in_word;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_bias_reg  <= '0;
            init_y_reg     <= '0;
            init_x_reg     <= '0;
            max_epochs_reg <= MAX_EPOCHS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_INIT_BIAS:  init_bias_reg  <= cfg_wdata;
                CFG_INIT_Y:     init_y_reg     <= cfg_wdata;
                CFG_INIT_X:     init_x_reg     <= cfg_wdata;
                CFG_MAX_EPOCHS: max_epochs_reg <= cfg_wdata[EPOCH_BITS-1:0];
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Weights, sweep bookkeeping and training status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            idx_reg         <= '0;
            epoch_reg       <= '0;
            w_bias_reg      <= '0;
            w_y_reg         <= '0;
            w_x_reg         <= '0;
            last_epochs_reg <= '0;
            last_conv_reg   <= 1'b0;
            sat_reg         <= 1'b0;
            clip_reg        <= 1'b0;
            clean_reg       <= 1'b0;
            predict_reg     <= 1'b0;
            pred_reg        <= 1'b0;
        end else begin
            count_reg <= count_next;
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        predict_reg <= (in_op == OP_PREDICT);
                        pred_reg    <= 1'b0;
                        if (in_op == OP_TRAIN) begin
                            w_bias_reg <= init_bias_reg;
                            w_y_reg    <= init_y_reg;
                            w_x_reg    <= init_x_reg;
                            epoch_reg  <= '0;
                            clip_reg   <= 1'b0;
                            clean_reg  <= 1'b0;
                        end
                    end
                end
                ST_EPOCH: begin
                    if (epoch_go) begin
                        clean_reg <= 1'b1;
                        epoch_reg <= epoch_reg + EPOCH_BITS'(1);
                        idx_reg   <= '0;
                    end else begin
                        last_epochs_reg <= epoch_reg;
                        last_conv_reg   <= (epoch_reg != '0) && clean_reg;
                        sat_reg         <= clip_reg;
                    end
                end
                ST_DECIDE: begin
                    if (predict_reg) begin
                        pred_reg <= !alu_stat.act_neg;
                    end else if (sample_hit) begin
                        idx_reg <= idx_reg + CNT_BITS'(1);
                    end else begin
                        clean_reg <= 1'b0;
                    end
                end
                ST_UPD_X: begin
                    w_x_reg  <= alu_sum;
                    clip_reg <= clip_reg | alu_stat.clipped;
                end
                ST_UPD_Y: begin
                    w_y_reg  <= alu_sum;
                    clip_reg <= clip_reg | alu_stat.clipped;
                end
                ST_UPD_B: begin
                    w_bias_reg <= alu_sum;
                    clip_reg   <= clip_reg | alu_stat.clipped;
                    idx_reg    <= idx_reg + CNT_BITS'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: holds a beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'b0000,
                            COUNT_BITS'(count_next),
                            sat_reg,
                            last_conv_reg,
                            last_epochs_reg,
                            w_x_reg,
                            w_y_reg,
                            w_bias_reg,
                            out_pred};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
